@@ rtl/spp_mmse_pkg.sv @@
// ----------------------------------------------------------------------------
// spp_mmse_pkg
// Shared types, codes and constants of the speech presence noise estimator.
// ----------------------------------------------------------------------------
package spp_mmse_pkg;

    // item kinds
    typedef enum logic [2:0] {
        KIND_LOAD  = 3'd0,
        KIND_RUN   = 3'd1,
        KIND_READ  = 3'd2,
        KIND_SEED  = 3'd3,
        KIND_SET   = 3'd4,
        KIND_FLOOR = 3'd5
    } spp_mmse_kind_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_BINS   = 3'd0,
        CFG_XI     = 3'd1,
        CFG_CAP    = 3'd2,
        CFG_ALPHA  = 3'd3,
        CFG_KEEP   = 3'd4,
        CFG_NEWW   = 3'd5,
        CFG_THRESH = 3'd6
    } spp_mmse_cfg_idx_t;

    localparam logic       ANS_STATUS = 1'b0;
    localparam logic       ANS_READ   = 1'b1;

    localparam logic [1:0] FS_SILENT_FIRST = 2'd0;
    localparam logic [1:0] FS_CAPTURED     = 2'd1;
    localparam logic [1:0] FS_SILENT_HELD  = 2'd2;
    localparam logic [1:0] FS_UPDATED      = 2'd3;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [16:0] ONE_Q16   = 17'h10000;

    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;

    typedef struct packed {
        logic [15:0] xi;
        logic [15:0] cap;
        logic [15:0] alpha;
        logic [15:0] keep;
        logic [15:0] neww;
    } spp_mmse_cfg_t;

    typedef struct packed {
        logic start;
        logic prep;
    } spp_mmse_bin_cmd_t;

    // 2^(-j/16) in Q1.16
    function automatic logic [16:0] pow2_neg16(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/spp_mmse_noise_psd_estimator_unit.sv @@
// ----------------------------------------------------------------------------
// spp_mmse_noise_psd_estimator_unit
// Per-bin noise power estimator driven by speech presence probability.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  item      item_valid / item_ready    kind, bin_index, bin_power
//  result    result_valid / result_ready answer_kind, noise_value, frame_status
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
//  a run makes a sum pass and a threshold test, then a zero, capture or hold
//  pass, or an update pass in which each bin goes through the shared divider
//  twice. read items also wait for the result register. after reset every
//  entry of the noise store is cleared before the first item is taken. a
//  stalled result holds the next run or read item in its emit state and
//  blocks items behind it.
//
module spp_mmse_noise_psd_estimator_unit #(
    parameter int MAX_BINS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [2:0]  kind,
    input  logic [9:0]  bin_index,
    input  logic [31:0] bin_power,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        answer_kind,
    output logic [31:0] noise_value,
    output logic [1:0]  frame_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import spp_mmse_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);
    localparam int SW = 32 + CW;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_FLOOR, ST_STREAM, ST_THRESH, ST_DECIDE,
        ST_PREP_WAIT, ST_UPD_RD, ST_UPD_CAP, ST_UPD_WAIT, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SM_SUM, SM_ZERO, SM_CAPTURE, SM_HOLD
    } stream_mode_t;

    // configuration
    logic [10:0] bins_reg;
    logic [15:0] xi_reg, cap_reg, alpha_reg, keep_reg, neww_reg;
    logic [31:0] thr_reg;

    state_t       state_reg, state_next;
    stream_mode_t mode_reg, mode_next;
    logic         awaiting_reg, awaiting_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] k_reg, k_next;
    logic          pipe_vld_reg, pipe_vld_next;
    logic [AW-1:0] pipe_addr_reg, pipe_addr_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [SW-1:0] thr_n_reg, thr_n_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          ok_reg, ok_next;
    logic [31:0]   pw_reg, pw_next;
    logic          res_kind_reg, res_kind_next;
    logic [31:0]   res_value_reg, res_value_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg, out_kind_next;
    logic [31:0]   out_value_reg, out_value_next;
    logic [1:0]    out_status_reg, out_status_next;

    logic          spec_we, nq_we, outm_we;
    logic [AW-1:0] spec_waddr, nq_waddr, outm_waddr;
    logic [AW-1:0] spec_raddr, nq_raddr, outm_raddr;
    logic [31:0]   spec_wdata, outm_wdata, spec_rdata, outm_rdata;
    logic [47:0]   nq_wdata, nq_rdata;

    spp_mmse_bin_cmd_t bin_cmd;
    spp_mmse_cfg_t     bin_cfg;
    logic              bin_done;
    logic [31:0]       bin_nv;
    logic [15:0]       bin_snew;

    logic          accept;
    logic [AW-1:0] addr_in;
    logic          ok_in;
    logic [CW-1:0] n_clamp;
    logic          issue;

    spp_mmse_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_spec_ram (
        .clk   (clk),
        .we    (spec_we),
        .waddr (spec_waddr),
        .wdata (spec_wdata),
        .raddr (spec_raddr),
        .rdata (spec_rdata)
    );

    // noise estimate in the upper 32 bits, smoothed presence in the lower 16
    spp_mmse_ram #(.WIDTH(48), .DEPTH(MAX_BINS)) u_nq_ram (
        .clk   (clk),
        .we    (nq_we),
        .waddr (nq_waddr),
        .wdata (nq_wdata),
        .raddr (nq_raddr),
        .rdata (nq_rdata)
    );

    spp_mmse_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_outm_ram (
        .clk   (clk),
        .we    (outm_we),
        .waddr (outm_waddr),
        .wdata (outm_wdata),
        .raddr (outm_raddr),
        .rdata (outm_rdata)
    );

    assign bin_cfg.xi    = xi_reg;
    assign bin_cfg.cap   = cap_reg;
    assign bin_cfg.alpha = alpha_reg;
    assign bin_cfg.keep  = keep_reg;
    assign bin_cfg.neww  = neww_reg;

    spp_mmse_bin u_bin (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bin_cmd),
        .cfg   (bin_cfg),
        .y     (spec_rdata),
        .q     (nq_rdata[47:16]),
        .s     (nq_rdata[15:0]),
        .done  (bin_done),
        .nv    (bin_nv),
        .s_new (bin_snew)
    );

    assign cfg_ready  = 1'b1;
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign addr_in    = AW'(bin_index);
    assign ok_in      = {22'b0, bin_index} < 32'(MAX_BINS);
    assign issue      = k_reg < n_reg;

    always_comb
    begin
        if (bins_reg == 11'd0)
        begin
            n_clamp = CW'(1);
        end
        else if ({21'b0, bins_reg} > 32'(MAX_BINS))
        begin
            n_clamp = CW'(MAX_BINS);
        end
        else
        begin
            n_clamp = CW'(bins_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_reg  <= 11'd513;
            xi_reg    <= 16'd8090;
            cap_reg   <= 16'd64880;
            alpha_reg <= 16'd52429;
            keep_reg  <= 16'd58982;
            neww_reg  <= 16'd6554;
            thr_reg   <= 32'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (spp_mmse_cfg_idx_t'(cfg_index))
                CFG_BINS:   bins_reg  <= cfg_data[10:0];
                CFG_XI:     xi_reg    <= cfg_data[15:0];
                CFG_CAP:    cap_reg   <= cfg_data[15:0];
                CFG_ALPHA:  alpha_reg <= cfg_data[15:0];
                CFG_KEEP:   keep_reg  <= cfg_data[15:0];
                CFG_NEWW:   neww_reg  <= cfg_data[15:0];
                CFG_THRESH: thr_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        awaiting_next   = awaiting_reg;
        clr_next        = clr_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        pipe_vld_next   = 1'b0;
        pipe_addr_next  = pipe_addr_reg;
        sum_next        = sum_reg;
        thr_n_next      = thr_n_reg;
        idx_next        = idx_reg;
        ok_next         = ok_reg;
        pw_next         = pw_reg;
        res_kind_next   = res_kind_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_kind_next   = out_kind_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        spec_we         = 1'b0;
        spec_waddr      = addr_in;
        spec_wdata      = bin_power;
        spec_raddr      = '0;
        nq_we           = 1'b0;
        nq_waddr        = addr_in;
        nq_wdata        = '0;
        nq_raddr        = '0;
        outm_we         = 1'b0;
        outm_waddr      = pipe_addr_reg;
        outm_wdata      = '0;
        outm_raddr      = '0;
        bin_cmd.start   = 1'b0;
        bin_cmd.prep    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                nq_we    = 1'b1;
                nq_waddr = clr_reg[AW-1:0];
                nq_wdata = '0;
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(MAX_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = addr_in;
                    ok_next  = ok_in;
                    pw_next  = bin_power;
                    case (spp_mmse_kind_t'(kind))
                        KIND_LOAD:
                        begin
                            spec_we = ok_in;
                        end
                        KIND_RUN:
                        begin
                            n_next     = n_clamp;
                            k_next     = '0;
                            sum_next   = '0;
                            mode_next  = SM_SUM;
                            state_next = ST_STREAM;
                        end
                        KIND_READ:
                        begin
                            outm_raddr = addr_in;
                            state_next = ST_READ;
                        end
                        KIND_SEED, KIND_SET:
                        begin
                            nq_we    = ok_in;
                            nq_wdata = {(bin_power == 32'd0) ? 32'd1 : bin_power, 16'd0};
                            if (spp_mmse_kind_t'(kind) == KIND_SET)
                            begin
                                awaiting_next = 1'b0;
                            end
                        end
                        KIND_FLOOR:
                        begin
                            nq_raddr   = addr_in;
                            state_next = ST_FLOOR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                res_kind_next   = ANS_READ;
                res_value_next  = ok_reg ? outm_rdata : 32'd0;
                res_status_next = FS_SILENT_FIRST;
                state_next      = ST_EMIT;
            end
            ST_FLOOR:
            begin
                nq_waddr = idx_reg;
                nq_wdata = {pw_reg, nq_rdata[15:0]};
                nq_we    = ok_reg && (nq_rdata[47:16] < pw_reg);
                state_next = ST_IDLE;
            end
            ST_STREAM:
            begin
                // read at k, act in the next cycle at pipe_addr
                spec_raddr     = k_reg[AW-1:0];
                nq_raddr       = k_reg[AW-1:0];
                pipe_vld_next  = issue;
                pipe_addr_next = k_reg[AW-1:0];
                if (issue)
                begin
                    k_next = k_reg + CW'(1);
                end
                if (pipe_vld_reg)
                begin
                    case (mode_reg)
                        SM_SUM:
                        begin
                            sum_next = sum_reg + SW'(spec_rdata);
                        end
                        SM_ZERO:
                        begin
                            outm_we    = 1'b1;
                            outm_wdata = '0;
                        end
                        SM_CAPTURE:
                        begin
                            outm_we    = 1'b1;
                            outm_wdata = spec_rdata;
                            nq_we      = 1'b1;
                            nq_waddr   = pipe_addr_reg;
                            nq_wdata   = {spec_rdata, 16'd0};
                        end
                        SM_HOLD:
                        begin
                            outm_we    = 1'b1;
                            outm_wdata = nq_rdata[47:16];
                        end
                        default: ;
                    endcase
                end
                if (!issue && !pipe_vld_reg)
                begin
                    res_kind_next  = ANS_STATUS;
                    res_value_next = '0;
                    case (mode_reg)
                        SM_SUM:
                        begin
                            state_next = ST_THRESH;
                        end
                        SM_ZERO:
                        begin
                            res_status_next = FS_SILENT_FIRST;
                            state_next      = ST_EMIT;
                        end
                        SM_CAPTURE:
                        begin
                            res_status_next = FS_CAPTURED;
                            awaiting_next   = 1'b0;
                            state_next      = ST_EMIT;
                        end
                        SM_HOLD:
                        begin
                            res_status_next = FS_SILENT_HELD;
                            state_next      = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_THRESH:
            begin
                // floor(sum / n) < thr  is the same as  sum < thr * n
                thr_n_next = SW'(thr_reg) * SW'(n_reg);
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                k_next = '0;
                if (awaiting_reg)
                begin
                    mode_next  = (sum_reg < thr_n_reg) ? SM_ZERO : SM_CAPTURE;
                    state_next = ST_STREAM;
                end
                else if (sum_reg < thr_n_reg)
                begin
                    mode_next  = SM_HOLD;
                    state_next = ST_STREAM;
                end
                else
                begin
                    bin_cmd.start = 1'b1;
                    bin_cmd.prep  = 1'b1;
                    state_next    = ST_PREP_WAIT;
                end
            end
            ST_PREP_WAIT:
            begin
                if (bin_done)
                begin
                    state_next = ST_UPD_RD;
                end
            end
            ST_UPD_RD:
            begin
                spec_raddr = k_reg[AW-1:0];
                nq_raddr   = k_reg[AW-1:0];
                if (issue)
                begin
                    state_next = ST_UPD_CAP;
                end
                else
                begin
                    res_kind_next   = ANS_STATUS;
                    res_value_next  = '0;
                    res_status_next = FS_UPDATED;
                    state_next      = ST_EMIT;
                end
            end
            ST_UPD_CAP:
            begin
                bin_cmd.start = 1'b1;
                state_next    = ST_UPD_WAIT;
            end
            ST_UPD_WAIT:
            begin
                if (bin_done)
                begin
                    nq_we      = 1'b1;
                    nq_waddr   = k_reg[AW-1:0];
                    nq_wdata   = {bin_nv, bin_snew};
                    outm_we    = 1'b1;
                    outm_waddr = k_reg[AW-1:0];
                    outm_wdata = bin_nv;
                    k_next     = k_reg + CW'(1);
                    state_next = ST_UPD_RD;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = res_kind_reg;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mode_reg      <= SM_SUM;
            awaiting_reg  <= 1'b1;
            clr_reg       <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            pipe_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            awaiting_reg  <= awaiting_next;
            clr_reg       <= clr_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            pipe_vld_reg  <= pipe_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg  <= pipe_addr_next;
        sum_reg        <= sum_next;
        thr_n_reg      <= thr_n_next;
        idx_reg        <= idx_next;
        ok_reg         <= ok_next;
        pw_reg         <= pw_next;
        res_kind_reg   <= res_kind_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_kind_reg   <= out_kind_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign result_valid = out_valid_reg;
    assign answer_kind  = out_kind_reg;
    assign noise_value  = out_value_reg;
    assign frame_status = out_status_reg;

    // bin unit only finishes while a pass waits for it
    a_bin_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        bin_done |-> (state_reg == ST_PREP_WAIT || state_reg == ST_UPD_WAIT))
        else $error("bin unit finished outside a wait state");

    // the frame pass never walks beyond the bin count
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STREAM || state_reg == ST_UPD_RD) |-> (k_reg <= n_reg && n_reg != '0))
        else $error("bin counter out of range");

    // a pending result waits while the output register is still full
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid_reg && !result_ready) |=> state_reg == ST_EMIT)
        else $error("result register overwritten");

endmodule

@@ rtl/spp_mmse_ram.sv @@
// ----------------------------------------------------------------------------
// spp_mmse_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module spp_mmse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/spp_mmse_div.sv @@
// ----------------------------------------------------------------------------
// spp_mmse_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spp_mmse_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [spp_mmse_pkg::DIV_NW-1:0]     num,
    input  logic [spp_mmse_pkg::DIV_DW-1:0]     den,
    output logic                                done,
    output logic [spp_mmse_pkg::DIV_NW-1:0]     quot
);
    import spp_mmse_pkg::*;

    localparam int CNTW = $clog2(DIV_NW + 1);

    logic [CNTW-1:0]   cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_NW-1:0] quot_reg, quot_next;
    logic [DIV_DW-1:0] rem_reg,  rem_next;
    logic [DIV_DW-1:0] den_reg,  den_next;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   trial;
    logic              ge;

    assign shifted = {rem_reg, quot_reg[DIV_NW-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next  = CNTW'(DIV_NW);
            busy_next = 1'b1;
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial[DIV_DW-1:0] : shifted[DIV_DW-1:0];
            quot_next = {quot_reg[DIV_NW-2:0], ge};
            cnt_next  = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ rtl/spp_mmse_bin.sv @@
// ----------------------------------------------------------------------------
// spp_mmse_bin
// Per-bin update: presence probability, MMSE estimate and smoothing, on one
// shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
module spp_mmse_bin (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spp_mmse_pkg::spp_mmse_bin_cmd_t   cmd,
    input  spp_mmse_pkg::spp_mmse_cfg_t       cfg,
    input  logic [31:0]                       y,
    input  logic [31:0]                       q,
    input  logic [15:0]                       s,
    output logic                              done,
    output logic [31:0]                       nv,
    output logic [15:0]                       s_new
);
    import spp_mmse_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE, B_T_WAIT, B_YT, B_A_DIV, B_A_WAIT, B_B_MUL, B_M_LATCH, B_M_MUL,
        B_E_CALC, B_D_MUL, B_P_DIV, B_P_WAIT, B_M1, B_M2, B_M3, B_M4, B_M5,
        B_M6, B_M7
    } bin_state_t;

    bin_state_t  state_reg, state_next;
    logic        done_reg, done_next;
    logic [15:0] t_reg, t_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] q_reg, q_next;
    logic [15:0] s_reg, s_next;
    logic [20:0] a_reg, a_next;
    logic [21:0] b_reg, b_next;
    logic [16:0] e_reg, e_next;
    logic [16:0] p_reg, p_next;
    logic [31:0] mmse_reg, mmse_next;
    logic [31:0] nv_reg, nv_next;
    logic [15:0] snew_reg, snew_next;
    logic [48:0] acc_reg, acc_next;
    logic [48:0] prod_reg, prod_next;

    logic [31:0]       mul_a;
    logic [16:0]       mul_b;
    logic [49:0]       sum_w;
    logic [16:0]       tj, tj1, m_w, pq;
    logic [24:0]       rnd_w;
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_quot;
    logic [DIV_DW-1:0] div_den;

    spp_mmse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign sum_w     = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign prod_next = {17'b0, mul_a} * {32'b0, mul_b};
    assign tj        = pow2_neg16({1'b0, b_reg[15:12]});
    assign tj1       = pow2_neg16(5'({1'b0, b_reg[15:12]} + 5'd1));
    assign rnd_w     = prod_reg[24:0] + 25'd2048;
    assign m_w       = tj - {5'b0, rnd_w[23:12]};
    assign pq        = div_quot[16:0];

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        t_next     = t_reg;
        y_next     = y_reg;
        q_next     = q_reg;
        s_next     = s_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        e_next     = e_reg;
        p_next     = p_reg;
        mmse_next  = mmse_reg;
        nv_next    = nv_reg;
        snew_next  = snew_reg;
        acc_next   = acc_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd.start && cmd.prep)
                begin
                    // t = xi / (1 + xi) in Q0.16
                    div_start  = 1'b1;
                    div_num    = {16'b0, cfg.xi, 16'b0};
                    div_den    = 32'd256 + {16'b0, cfg.xi};
                    state_next = B_T_WAIT;
                end
                else if (cmd.start)
                begin
                    y_next     = y;
                    q_next     = q;
                    s_next     = s;
                    state_next = B_YT;
                end
            end
            B_T_WAIT:
            begin
                if (div_done)
                begin
                    t_next     = div_quot[15:0];
                    done_next  = 1'b1;
                    state_next = B_IDLE;
                end
            end
            B_YT:
            begin
                mul_a      = y_reg;
                mul_b      = {1'b0, t_reg};
                state_next = B_A_DIV;
            end
            B_A_DIV:
            begin
                div_start  = 1'b1;
                div_num    = prod_reg[47:0];
                div_den    = (q_reg == 32'd0) ? 32'd1 : q_reg;
                state_next = B_A_WAIT;
            end
            B_A_WAIT:
            begin
                if (div_done)
                begin
                    if (div_quot[47:21] != '0)
                    begin
                        e_next     = '0;
                        state_next = B_D_MUL;
                    end
                    else
                    begin
                        a_next     = div_quot[20:0];
                        state_next = B_B_MUL;
                    end
                end
            end
            B_B_MUL:
            begin
                mul_a      = {11'b0, a_reg};
                mul_b      = LOG2E_Q16;
                state_next = B_M_LATCH;
            end
            B_M_LATCH:
            begin
                b_next     = prod_reg[37:16];
                state_next = B_M_MUL;
            end
            B_M_MUL:
            begin
                // linear interpolation between table points
                mul_a      = {15'b0, tj - tj1};
                mul_b      = {5'b0, b_reg[11:0]};
                state_next = B_E_CALC;
            end
            B_E_CALC:
            begin
                if (b_reg[21:16] >= 6'd17)
                begin
                    e_next = '0;
                end
                else
                begin
                    e_next = m_w >> b_reg[20:16];
                end
                state_next = B_D_MUL;
            end
            B_D_MUL:
            begin
                mul_a      = {15'b0, e_reg};
                mul_b      = 17'd256 + {1'b0, cfg.xi};
                state_next = B_P_DIV;
            end
            B_P_DIV:
            begin
                div_start  = 1'b1;
                div_num    = 48'h0001_0000_0000;
                div_den    = 32'd65536 + {7'b0, prod_reg[32:8]};
                state_next = B_P_WAIT;
            end
            B_P_WAIT:
            begin
                if (div_done)
                begin
                    // stagnation cap
                    if (s_reg > cfg.cap && pq > {1'b0, cfg.cap})
                    begin
                        p_next = {1'b0, cfg.cap};
                    end
                    else
                    begin
                        p_next = pq;
                    end
                    state_next = B_M1;
                end
            end
            B_M1:
            begin
                mul_a      = y_reg;
                mul_b      = ONE_Q16 - p_reg;
                state_next = B_M2;
            end
            B_M2:
            begin
                acc_next   = prod_reg;
                mul_a      = q_reg;
                mul_b      = p_reg;
                state_next = B_M3;
            end
            B_M3:
            begin
                mmse_next  = sum_w[47:16];
                mul_a      = q_reg;
                mul_b      = {1'b0, cfg.alpha};
                state_next = B_M4;
            end
            B_M4:
            begin
                acc_next   = prod_reg;
                mul_a      = mmse_reg;
                mul_b      = ONE_Q16 - {1'b0, cfg.alpha};
                state_next = B_M5;
            end
            B_M5:
            begin
                nv_next    = sum_w[47:16];
                mul_a      = {16'b0, s_reg};
                mul_b      = {1'b0, cfg.keep};
                state_next = B_M6;
            end
            B_M6:
            begin
                acc_next   = prod_reg;
                mul_a      = {15'b0, p_reg};
                mul_b      = {1'b0, cfg.neww};
                state_next = B_M7;
            end
            B_M7:
            begin
                snew_next  = (sum_w[49:32] != '0) ? 16'hFFFF : sum_w[31:16];
                done_next  = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        y_reg    <= y_next;
        q_reg    <= q_next;
        s_reg    <= s_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        e_reg    <= e_next;
        p_reg    <= p_next;
        mmse_reg <= mmse_next;
        nv_reg   <= nv_next;
        snew_reg <= snew_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign done  = done_reg;
    assign nv    = nv_reg;
    assign s_new = snew_reg;

endmodule
